@@ design/arga_pkg.sv @@
// Shared widths, types and register codes for the affine residual gradient accumulator.
package arga_pkg;

  localparam int ACC_W      = 48;
  localparam int COEF_FRAC  = 16;
  localparam int COEF_W     = 32;
  localparam int COORD_W    = 16;
  localparam int COORD_FRAC = 4;
  localparam int OUT_W      = 48;
  localparam int CNT_OUT_W  = 16;
  localparam int NUM_COEF   = 6;
  localparam int CFG_IDX_W  = 3;

  localparam int RES_FRAC   = COEF_FRAC + COORD_FRAC;
  localparam int MAG_W      = COEF_W + COORD_W + 1;
  localparam int E_W        = MAG_W + 1;
  localparam int SQ_W       = 2 * MAG_W + 1;
  localparam int SQ_SHIFT   = 2 * RES_FRAC - 32;
  localparam int S_W        = SQ_W - SQ_SHIFT;
  localparam int RT_W       = (S_W + 1) / 2;
  localparam int RAD_W      = 2 * RT_W;
  localparam int NS         = 32 - RES_FRAC;
  localparam int UNIT_FRAC  = 16;
  localparam int QB         = UNIT_FRAC + 1;
  localparam int TERM_W     = QB + COORD_W - COORD_FRAC + 1;
  localparam int CNT_W      = $clog2(MAG_W);

  localparam logic [QB-1:0]     UNIT_ONE   = QB'(1) << UNIT_FRAC;
  localparam logic [COEF_W-1:0] COEF_ONE   = COEF_W'(1) << COEF_FRAC;
  localparam logic [E_W-1:0]    ROUND_HALF = E_W'(1) << (COORD_FRAC - 1);

  localparam int C_A11 = 0;
  localparam int C_A12 = 1;
  localparam int C_A13 = 2;
  localparam int C_A21 = 3;
  localparam int C_A22 = 4;
  localparam int C_A23 = 5;

  localparam logic [CFG_IDX_W-1:0] REG_A11  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A12  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A13  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A21  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A22  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A23  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD = 3'd6;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_SQR   = 8'b0000_0100,
    S_ROOT  = 8'b0000_1000,
    S_DIVX  = 8'b0001_0000,
    S_DIVY  = 8'b0010_0000,
    S_SCALE = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } arga_state_e;

  typedef struct packed {
    logic [NUM_COEF-1:0][COEF_W-1:0] coef;
    logic                            grad_en;
  } arga_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] test_x;
    logic [COORD_W-1:0] test_y;
    logic [COORD_W-1:0] ref_x;
    logic [COORD_W-1:0] ref_y;
    logic               last_pair;
  } arga_pair_t;

  typedef struct packed {
    logic                            valid;
    logic                            last;
    logic                            upd;
    logic [RT_W-1:0]                 root;
    logic [NUM_COEF-1:0][TERM_W-1:0] term;
  } arga_terms_t;

  typedef struct packed {
    logic [OUT_W-1:0]                total_distance;
    logic [NUM_COEF-1:0][OUT_W-1:0]  grad;
    logic [CNT_OUT_W-1:0]            pair_count;
  } arga_result_t;

endpackage

@@ design/arga_if.sv @@
// Handshake interfaces for point pairs, configuration writes and results.
interface arga_pair_if;
  import arga_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] test_x;
  logic [COORD_W-1:0] test_y;
  logic [COORD_W-1:0] ref_x;
  logic [COORD_W-1:0] ref_y;
  logic               last_pair;
  modport source (output valid, test_x, test_y, ref_x, ref_y, last_pair, input ready);
  modport sink (input valid, test_x, test_y, ref_x, ref_y, last_pair, output ready);
endinterface

interface arga_cfg_if;
  import arga_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface arga_result_if;
  import arga_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OUT_W-1:0]        total_distance;
  logic signed [OUT_W-1:0] grad_a11;
  logic signed [OUT_W-1:0] grad_a12;
  logic signed [OUT_W-1:0] grad_a13;
  logic signed [OUT_W-1:0] grad_a21;
  logic signed [OUT_W-1:0] grad_a22;
  logic signed [OUT_W-1:0] grad_a23;
  logic [CNT_OUT_W-1:0]    pair_count;
  modport source (output valid, total_distance, grad_a11, grad_a12, grad_a13, grad_a21,
                  grad_a22, grad_a23, pair_count, input ready);
  modport sink (input valid, total_distance, grad_a11, grad_a12, grad_a13, grad_a21,
                grad_a22, grad_a23, pair_count, output ready);
endinterface

@@ design/affine_residual_gradient_accumulator.sv @@
// Top level: maps matched point pairs through an affine transform and accumulates L2 cost.
// An item is finished before the next one can be accepted; the serial squarer (98 steps),
// the bit-serial square root (46 steps) and, when its gradient terms are formed, two
// 17-step divisions run in turn on one sequencer.
// A result appears in the cycle after its last item is taken and waits in its own register.
// Asynchronous active-low reset clears all sums and restores the identity transform with
// gradient mode on.
module affine_residual_gradient_accumulator (
  input logic           clk_i,
  input logic           rst_ni,
  arga_pair_if.sink     pair_i,
  arga_cfg_if.sink      cfg_i,
  arga_result_if.source result_o
);
  import arga_pkg::*;

  logic [NUM_COEF-1:0][COEF_W-1:0] coef_q;
  logic gen_q;
  arga_cfg_t cfg;
  arga_pair_t pair;
  arga_terms_t terms;
  arga_result_t res;
  logic acc_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= {{COEF_W{1'b0}}, COEF_ONE, {(3*COEF_W){1'b0}}, COEF_ONE};
      gen_q  <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_A11:  coef_q[C_A11] <= cfg_i.data;
        REG_A12:  coef_q[C_A12] <= cfg_i.data;
        REG_A13:  coef_q[C_A13] <= cfg_i.data;
        REG_A21:  coef_q[C_A21] <= cfg_i.data;
        REG_A22:  coef_q[C_A22] <= cfg_i.data;
        REG_A23:  coef_q[C_A23] <= cfg_i.data;
        REG_GRAD: gen_q         <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.coef    = coef_q;
  assign cfg.grad_en = gen_q;

  assign pair = {pair_i.test_x, pair_i.test_y, pair_i.ref_x, pair_i.ref_y, pair_i.last_pair};

  arga_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (pair_i.valid),
    .in_ready_o    (pair_i.ready),
    .pair_i        (pair),
    .cfg_i         (cfg),
    .terms_o       (terms),
    .terms_ready_i (acc_ready)
  );

  arga_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .terms_i     (terms),
    .ready_o     (acc_ready),
    .res_valid_o (result_o.valid),
    .res_ready_i (result_o.ready),
    .res_o       (res)
  );

  assign result_o.total_distance = res.total_distance;
  assign result_o.grad_a11       = res.grad[C_A11];
  assign result_o.grad_a12       = res.grad[C_A12];
  assign result_o.grad_a13       = res.grad[C_A13];
  assign result_o.grad_a21       = res.grad[C_A21];
  assign result_o.grad_a22       = res.grad[C_A22];
  assign result_o.grad_a23       = res.grad[C_A23];
  assign result_o.pair_count     = res.pair_count;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_i.valid && pair_i.ready |=> !pair_i.ready)
    else $error("Pair accepted while the previous item was still in progress.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(terms.valid && terms.last && acc_ready))
    else $error("Result appeared without a finished last item.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    terms.valid && terms.upd |-> terms.root != '0)
    else $error("Gradient terms formed for a zero distance.");

endmodule

@@ design/arga_core.sv @@
// Sequencer and shared iterative arithmetic: residual, distance and unit gradient terms.
module arga_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  arga_pkg::arga_pair_t  pair_i,
  input  arga_pkg::arga_cfg_t   cfg_i,
  output arga_pkg::arga_terms_t terms_o,
  input  logic                  terms_ready_i
);
  import arga_pkg::*;

  arga_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic pass_q, pass_d;
  arga_pair_t pair_q, pair_d;
  logic signed [E_W-1:0] ex_q, ex_d, ey_q, ey_d;
  logic [SQ_W-1:0] mcand_q, mcand_d, sq_q, sq_d;
  logic [MAG_W-1:0] mplier_q, mplier_d;
  logic [RAD_W-1:0] rad_q, rad_d;
  logic [RT_W+1:0] rem_q, rem_d;
  logic [RT_W-1:0] root_q, root_d;
  logic [RT_W-1:0] drem_q, drem_d;
  logic [QB-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [QB-1:0] uxm_q, uxm_d, uym_q, uym_d;
  logic [NUM_COEF-1:0][TERM_W-1:0] term_q, term_d;
  logic upd_q, upd_d;

  logic [MAG_W-1:0] mx, my;
  logic [MAG_W+NS-1:0] nx, ny;
  logic [COEF_W-1:0] coef_sel, tr_sel;
  logic [COORD_W-1:0] crd_sel, rp_sel;
  logic [QB-1:0] mag_sel;
  logic signed [COEF_W:0] mul_a;
  logic signed [COORD_W:0] mul_b;
  logic signed [E_W-1:0] mul_p;
  logic signed [E_W-1:0] tr_ext, rp_ext, off, acc_in, msum, rnd;
  logic [RT_W+3:0] rem_sh, trial;
  logic [RT_W:0] r2;
  logic dge;
  logic [QB-1:0] cap;
  logic signed [TERM_W-1:0] sval;
  logic neg;

  assign mx = ex_q[E_W-1] ? MAG_W'(-ex_q) : MAG_W'(ex_q);
  assign my = ey_q[E_W-1] ? MAG_W'(-ey_q) : MAG_W'(ey_q);
  assign nx = {mx, {NS{1'b0}}};
  assign ny = {my, {NS{1'b0}}};

  // Shared multiplier: affine products during the residual, unit scaling at the end.
  always_comb begin
    coef_sel = cnt_q[1] ? (cnt_q[0] ? cfg_i.coef[C_A22] : cfg_i.coef[C_A21])
                        : (cnt_q[0] ? cfg_i.coef[C_A12] : cfg_i.coef[C_A11]);
    crd_sel  = cnt_q[0] ? pair_q.test_y : pair_q.test_x;
    mag_sel  = cnt_q[1] ? uym_q : uxm_q;
    if (state_q == S_MUL) begin
      mul_a = {coef_sel[COEF_W-1], coef_sel};
    end else begin
      mul_a = (COEF_W+1)'(mag_sel);
    end
    mul_b = {1'b0, crd_sel};
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    tr_sel = cnt_q[1] ? cfg_i.coef[C_A23] : cfg_i.coef[C_A13];
    rp_sel = cnt_q[1] ? pair_q.ref_y : pair_q.ref_x;
    tr_ext = {{(E_W-COEF_W){tr_sel[COEF_W-1]}}, tr_sel};
    rp_ext = {{(E_W-COORD_W-COEF_FRAC){1'b0}}, rp_sel, {COEF_FRAC{1'b0}}};
    off    = (tr_ext <<< COORD_FRAC) - rp_ext;
    acc_in = cnt_q[0] ? (cnt_q[1] ? ey_q : ex_q) : off;
    msum   = acc_in + mul_p;
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    r2     = {drem_q, dvd_q[QB-1]};
    dge    = r2 >= {1'b0, root_q};
    rnd    = mul_p + ROUND_HALF;
    sval   = TERM_W'(rnd >>> COORD_FRAC);
    neg    = cnt_q[1] ? ey_q[E_W-1] : ex_q[E_W-1];
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pass_d   = pass_q;
    pair_d   = pair_q;
    ex_d     = ex_q;
    ey_d     = ey_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    sq_d     = sq_q;
    rad_d    = rad_q;
    rem_d    = rem_q;
    root_d   = root_q;
    drem_d   = drem_q;
    dvd_d    = dvd_q;
    quo_d    = quo_q;
    uxm_d    = uxm_q;
    uym_d    = uym_q;
    term_d   = term_q;
    upd_d    = upd_q;
    cap      = (quo_d > UNIT_ONE) ? UNIT_ONE : quo_d;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pair_d  = pair_i;
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (cnt_q[1]) begin
          ey_d = msum;
        end else begin
          ex_d = msum;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(3)) begin
          cnt_d    = '0;
          pass_d   = 1'b0;
          sq_d     = '0;
          mcand_d  = SQ_W'(mx);
          mplier_d = mx;
          state_d  = S_SQR;
        end
      end
      S_SQR: begin
        if (mplier_q[0]) begin
          sq_d = sq_q + mcand_q;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MAG_W-1)) begin
          cnt_d = '0;
          if (!pass_q) begin
            pass_d   = 1'b1;
            mcand_d  = SQ_W'(my);
            mplier_d = my;
          end else begin
            rad_d   = RAD_W'(sq_d >> SQ_SHIFT);
            rem_d   = '0;
            root_d  = '0;
            state_d = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        if (rem_sh >= trial) begin
          rem_d  = (RT_W+2)'(rem_sh - trial);
          root_d = {root_q[RT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[RT_W+1:0];
          root_d = {root_q[RT_W-2:0], 1'b0};
        end
        rad_d = rad_q << 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(RT_W-1)) begin
          cnt_d = '0;
          if (cfg_i.grad_en && (root_d != '0)) begin
            upd_d   = 1'b1;
            drem_d  = RT_W'(nx >> QB);
            dvd_d   = nx[QB-1:0];
            state_d = S_DIVX;
          end else begin
            upd_d   = 1'b0;
            term_d  = '0;
            state_d = S_FIN;
          end
        end
      end
      S_DIVX, S_DIVY: begin
        drem_d = dge ? RT_W'(r2 - {1'b0, root_q}) : r2[RT_W-1:0];
        quo_d  = {quo_q[QB-2:0], dge};
        dvd_d  = dvd_q << 1;
        cnt_d  = cnt_q + 1'b1;
        cap    = (quo_d > UNIT_ONE) ? UNIT_ONE : quo_d;
        if (cnt_q == CNT_W'(QB-1)) begin
          cnt_d = '0;
          if (state_q == S_DIVX) begin
            uxm_d   = cap;
            drem_d  = RT_W'(ny >> QB);
            dvd_d   = ny[QB-1:0];
            state_d = S_DIVY;
          end else begin
            uym_d   = cap;
            state_d = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        case (cnt_q[1:0])
          2'd0:    term_d[C_A11] = neg ? -sval : sval;
          2'd1:    term_d[C_A12] = neg ? -sval : sval;
          2'd2:    term_d[C_A21] = neg ? -sval : sval;
          default: term_d[C_A22] = neg ? -sval : sval;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(3)) begin
          cnt_d         = '0;
          term_d[C_A13] = ex_q[E_W-1] ? -TERM_W'(uxm_q) : TERM_W'(uxm_q);
          term_d[C_A23] = ey_q[E_W-1] ? -TERM_W'(uym_q) : TERM_W'(uym_q);
          state_d       = S_FIN;
        end
      end
      S_FIN: begin
        if (terms_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign terms_o.valid = (state_q == S_FIN);
  assign terms_o.last  = pair_q.last_pair;
  assign terms_o.upd   = upd_q;
  assign terms_o.root  = root_q;
  assign terms_o.term  = term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q   <= pair_d;
    ex_q     <= ex_d;
    ey_q     <= ey_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    sq_q     <= sq_d;
    rad_q    <= rad_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    drem_q   <= drem_d;
    dvd_q    <= dvd_d;
    quo_q    <= quo_d;
    uxm_q    <= uxm_d;
    uym_q    <= uym_d;
    term_q   <= term_d;
    upd_q    <= upd_d;
  end

endmodule

@@ design/arga_accum.sv @@
// Saturating cost, gradient and pair count accumulators with the result register.
module arga_accum (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  arga_pkg::arga_terms_t terms_i,
  output logic                  ready_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output arga_pkg::arga_result_t res_o
);
  import arga_pkg::*;

  logic [ACC_W-1:0] dsum_q, dsum_d;
  logic [NUM_COEF-1:0][ACC_W-1:0] gsum_q, gsum_d;
  logic [CNT_OUT_W-1:0] pcnt_q, pcnt_d;
  logic res_valid_q, res_valid_d;
  arga_result_t res_q, res_d;

  logic [ACC_W:0] dadd;
  logic [ACC_W-1:0] dsat;
  logic signed [ACC_W:0] gadd;
  logic [NUM_COEF-1:0][ACC_W-1:0] gnew;
  logic [CNT_OUT_W-1:0] pnew;
  logic take;

  assign ready_o = !res_valid_q || res_ready_i;
  assign take    = terms_i.valid && ready_o;

  always_comb begin
    dadd = {1'b0, dsum_q} + (ACC_W+1)'(terms_i.root);
    dsat = dadd[ACC_W] ? '1 : dadd[ACC_W-1:0];
    gnew = gsum_q;
    for (int i = 0; i < NUM_COEF; i++) begin
      gadd = $signed({gsum_q[i][ACC_W-1], gsum_q[i]})
           + (ACC_W+1)'($signed(terms_i.term[i]));
      if (terms_i.upd) begin
        if (gadd[ACC_W] != gadd[ACC_W-1]) begin
          gnew[i] = gadd[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          gnew[i] = gadd[ACC_W-1:0];
        end
      end
    end
    pnew = (pcnt_q == '1) ? pcnt_q : pcnt_q + 1'b1;
  end

  always_comb begin
    dsum_d      = dsum_q;
    gsum_d      = gsum_q;
    pcnt_d      = pcnt_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    if (take) begin
      if (terms_i.last) begin
        res_d.total_distance = OUT_W'(dsat);
        for (int i = 0; i < NUM_COEF; i++) begin
          res_d.grad[i] = OUT_W'($signed(gnew[i]));
        end
        res_d.pair_count = pnew;
        res_valid_d      = 1'b1;
        dsum_d           = '0;
        gsum_d           = '0;
        pcnt_d           = '0;
      end else begin
        dsum_d = dsat;
        gsum_d = gnew;
        pcnt_d = pnew;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dsum_q      <= '0;
      gsum_q      <= '0;
      pcnt_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      dsum_q      <= dsum_d;
      gsum_q      <= gsum_d;
      pcnt_q      <= pcnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule
